@@ rtl/pelt_pkg.sv @@
// Shared types and constants of the priority / expiry LRU table.
package pelt_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam logic [30:0] INT_MAX = 31'h7fff_ffff;

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_EVICTED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_RESIZED  = 3'd6;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        key;
    logic signed [31:0] value;
    logic [6:0]         priority_req;
    logic [30:0]        expiry;
    logic [4:0]         new_capacity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        key_res;
    logic signed [31:0] value_res;
    logic [6:0]         priority_res;
    logic [30:0]        expiry_res;
    logic               last;
  } out_item_t;

endpackage

@@ rtl/pelt_mem.sv @@
// Single-port-write, single-port-read synchronous memory holding the entry records.
module pelt_mem #(
  parameter int DEPTH = pelt_pkg::ENTRIES_DEF,
  parameter int WIDTH = 134,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/priority_expiry_lru_table.sv @@
// Top level of the priority / expiry LRU table.
//
// Each command beat (start high while busy is low) sweeps the whole entry
// memory, one entry per cycle, to find the key, a free slot, the entry with
// the earliest expiry and the least recently used entry of the lowest
// priority. A get or set therefore sweeps the memory once before its single
// result beat, and busy stays high until that beat. A resize sweeps once for
// every entry it evicts and once more for the final resize-done beat, since
// each eviction rescans the memory. The record memory has one read port, and
// that port sets the rate. Result beats appear on out_item for exactly one
// cycle with out_valid high; the receiver cannot stall them, so it must take
// every beat. An operation code of three is not accepted and gives no result.
// The expiry limit is written through cfg_we / cfg_wdata; the user must do so
// only while idle, since the block itself does not enforce it.
module priority_expiry_lru_table #(
  parameter int ENTRIES  = pelt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = pelt_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pelt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output pelt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

  // One stored entry: the memory word.
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [31:0]         value;
    logic [6:0]          pri;
    logic [30:0]         exp;
    logic [31:0]         stamp;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  pelt_pkg::in_item_t  req_r, req_nxt;
  logic [30:0]         exp_lim_r, exp_lim_nxt;
  logic [LIM_W-1:0]    limit_r, limit_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [31:0]         use_r, use_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [IDX_W-1:0]    scan_r, scan_nxt;
  logic                proc_r, proc_nxt;
  logic [IDX_W-1:0]    pidx_r, pidx_nxt;

  // Search results gathered during a sweep.
  logic                hit_f_r, hit_f_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  rec_t                hit_rec_r, hit_rec_nxt;
  logic                free_f_r, free_f_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic                ex_f_r, ex_f_nxt;
  logic [IDX_W-1:0]    ex_idx_r, ex_idx_nxt;
  rec_t                ex_rec_r, ex_rec_nxt;
  logic                pr_f_r, pr_f_nxt;
  logic [IDX_W-1:0]    pr_idx_r, pr_idx_nxt;
  rec_t                pr_rec_r, pr_rec_nxt;
  logic [31:0]         pr_age_r, pr_age_nxt;

  logic                out_valid_r, out_valid_nxt;
  pelt_pkg::out_item_t out_r, out_nxt;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  rec_t                wr_rec;
  logic [REC_W-1:0]    rd_data;
  rec_t                rd_rec;
  logic                pv;
  logic [31:0]         age;
  logic [63:0]         key_in_ext;
  logic [KEY_BITS-1:0] req_key;
  logic [LIM_W-1:0]    cap_ext;
  logic                evict;
  logic                use_ex;
  rec_t                vict_rec;
  logic [IDX_W-1:0]    vict_idx;
  logic [IDX_W-1:0]    set_idx;

  pelt_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (REC_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_addr (scan_r),
    .rd_data (rd_data)
  );

  // Widen a stored key into the 32-bit result field.
  function automatic logic [31:0] key_out(input logic [KEY_BITS-1:0] k);
    logic [63:0] e;
    e = 64'(k);
    return e[31:0];
  endfunction

  assign key_in_ext = {32'd0, req_r.key};
  assign req_key    = key_in_ext[KEY_BITS-1:0];
  assign rd_rec     = rec_t'(rd_data);
  assign pv         = valid_r[pidx_r];
  assign age        = use_r - rd_rec.stamp;
  assign cap_ext    = LIM_W'(req_r.new_capacity);

  // The earliest expiry wins only when its expiry is at or below the limit.
  assign use_ex   = ex_f_r && (ex_rec_r.exp <= exp_lim_r);
  assign vict_rec = use_ex ? ex_rec_r : pr_rec_r;
  assign vict_idx = use_ex ? ex_idx_r : pr_idx_r;
  assign evict    = (cap_ext < limit_r) && (LIM_W'(count_r) > cap_ext) &&
                    (ex_f_r || pr_f_r);
  assign set_idx  = hit_f_r ? hit_idx_r : free_idx_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    exp_lim_nxt   = cfg_we ? cfg_wdata : exp_lim_r;
    limit_nxt     = limit_r;
    count_nxt     = count_r;
    use_nxt       = use_r;
    valid_nxt     = valid_r;
    scan_nxt      = scan_r;
    proc_nxt      = 1'b0;
    pidx_nxt      = scan_r;
    hit_f_nxt     = hit_f_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rec_nxt   = hit_rec_r;
    free_f_nxt    = free_f_r;
    free_idx_nxt  = free_idx_r;
    ex_f_nxt      = ex_f_r;
    ex_idx_nxt    = ex_idx_r;
    ex_rec_nxt    = ex_rec_r;
    pr_f_nxt      = pr_f_r;
    pr_idx_nxt    = pr_idx_r;
    pr_rec_nxt    = pr_rec_r;
    pr_age_nxt    = pr_age_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = set_idx;
    wr_rec        = hit_rec_r;

    // Fold the entry read in the previous cycle into the search results.
    if (proc_r) begin
      if (pv && !hit_f_r && (rd_rec.key == req_key)) begin
        hit_f_nxt   = 1'b1;
        hit_idx_nxt = pidx_r;
        hit_rec_nxt = rd_rec;
      end
      if (!pv && !free_f_r) begin
        free_f_nxt   = 1'b1;
        free_idx_nxt = pidx_r;
      end
      if (pv && (!ex_f_r || (rd_rec.exp < ex_rec_r.exp))) begin
        ex_f_nxt   = 1'b1;
        ex_idx_nxt = pidx_r;
        ex_rec_nxt = rd_rec;
      end
      if (pv && (!pr_f_r || (rd_rec.pri < pr_rec_r.pri) ||
                 ((rd_rec.pri == pr_rec_r.pri) && (age > pr_age_r)))) begin
        pr_f_nxt   = 1'b1;
        pr_idx_nxt = pidx_r;
        pr_rec_nxt = rd_rec;
        pr_age_nxt = age;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start && (in_item.operation != 2'd3)) begin
          req_nxt    = in_item;
          scan_nxt   = '0;
          hit_f_nxt  = 1'b0;
          free_f_nxt = 1'b0;
          ex_f_nxt   = 1'b0;
          pr_f_nxt   = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        proc_nxt = 1'b1;
        pidx_nxt = scan_r;
        if (scan_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        out_nxt.last  = 1'b1;
        state_nxt     = S_IDLE;
        case (req_r.operation)
          pelt_pkg::OP_GET: begin
            if (hit_f_r) begin
              wr_en               = 1'b1;
              wr_addr             = hit_idx_r;
              wr_rec              = hit_rec_r;
              wr_rec.stamp        = use_r + 32'd1;
              use_nxt             = use_r + 32'd1;
              out_nxt.status      = pelt_pkg::ST_HIT;
              out_nxt.key_res     = key_out(hit_rec_r.key);
              out_nxt.value_res   = hit_rec_r.value;
              out_nxt.priority_res = hit_rec_r.pri;
              out_nxt.expiry_res  = hit_rec_r.exp;
            end else begin
              out_nxt.status  = pelt_pkg::ST_MISS;
              out_nxt.key_res = key_out(req_key);
            end
          end
          pelt_pkg::OP_SET: begin
            if (hit_f_r || free_f_r) begin
              wr_en        = 1'b1;
              wr_addr      = set_idx;
              wr_rec.key   = req_key;
              wr_rec.value = req_r.value;
              wr_rec.pri   = req_r.priority_req;
              wr_rec.exp   = req_r.expiry;
              wr_rec.stamp = use_r + 32'd1;
              use_nxt      = use_r + 32'd1;
              if (!hit_f_r) begin
                valid_nxt[free_idx_r] = 1'b1;
                count_nxt             = count_r + 1'b1;
              end
              out_nxt.status = hit_f_r ? pelt_pkg::ST_UPDATED : pelt_pkg::ST_INSERTED;
              out_nxt.key_res      = key_out(req_key);
              out_nxt.value_res    = req_r.value;
              out_nxt.priority_res = req_r.priority_req;
              out_nxt.expiry_res   = req_r.expiry;
            end else begin
              out_nxt.status  = pelt_pkg::ST_FULL;
              out_nxt.key_res = key_out(req_key);
            end
          end
          pelt_pkg::OP_RESIZE: begin
            if (evict) begin
              // Report the victim, drop it and sweep again for the next one.
              out_nxt.status       = pelt_pkg::ST_EVICTED;
              out_nxt.key_res      = key_out(vict_rec.key);
              out_nxt.value_res    = vict_rec.value;
              out_nxt.priority_res = vict_rec.pri;
              out_nxt.expiry_res   = vict_rec.exp;
              out_nxt.last         = 1'b0;
              valid_nxt[vict_idx]  = 1'b0;
              count_nxt            = count_r - 1'b1;
              scan_nxt             = '0;
              hit_f_nxt            = 1'b0;
              free_f_nxt           = 1'b0;
              ex_f_nxt             = 1'b0;
              pr_f_nxt             = 1'b0;
              state_nxt            = S_SCAN;
            end else begin
              out_nxt.status = pelt_pkg::ST_RESIZED;
              limit_nxt      = cap_ext;
            end
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_lim_r   <= pelt_pkg::INT_MAX;
      limit_r     <= LIM_W'(ENTRIES);
      count_r     <= '0;
      use_r       <= '0;
      valid_r     <= '0;
      proc_r      <= 1'b0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      exp_lim_r   <= exp_lim_nxt;
      limit_r     <= limit_nxt;
      count_r     <= count_nxt;
      use_r       <= use_nxt;
      valid_r     <= valid_nxt;
      proc_r      <= proc_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pidx_r     <= pidx_nxt;
    hit_f_r    <= hit_f_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_rec_r  <= hit_rec_nxt;
    free_f_r   <= free_f_nxt;
    free_idx_r <= free_idx_nxt;
    ex_f_r     <= ex_f_nxt;
    ex_idx_r   <= ex_idx_nxt;
    ex_rec_r   <= ex_rec_nxt;
    pr_f_r     <= pr_f_nxt;
    pr_idx_r   <= pr_idx_nxt;
    pr_rec_r   <= pr_rec_nxt;
    pr_age_r   <= pr_age_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
